@@ rtl/pcmfc_pkg.sv @@
// pcmfc_pkg: shared types, constants and format decode helpers for the
// pcm sample format converter. No dependencies.
package pcmfc_pkg;

    // default number of fractional bits in the gain register
    localparam int GAIN_FRAC_BITS_DEF = 24;

    // width of a raw sample and of the gain register
    localparam int SAMPLE_W = 32;
    localparam int GAIN_W   = 32;
    localparam int FMT_W    = 3;

    // decoupling queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // configuration register indexes
    localparam int          CFG_IDX_W   = 2;
    localparam logic [1:0]  CFG_SRC_FMT = 2'd0;
    localparam logic [1:0]  CFG_DST_FMT = 2'd1;
    localparam logic [1:0]  CFG_GAIN    = 2'd2;

    // format codes
    localparam logic [2:0] FMT_S16 = 3'd2;

    // classified sample handed from front to back
    typedef struct packed {
        logic                s_neg;
        logic [SAMPLE_W-1:0] s_mag;
        logic                last;
    } t_cls;

    // configuration seen by the back part
    typedef struct packed {
        logic [FMT_W-1:0]  src_fmt;
        logic [FMT_W-1:0]  dst_fmt;
        logic [GAIN_W-1:0] gain;
    } t_cfg;

    // mask of the valid bits for a format
    function automatic logic [SAMPLE_W-1:0] fmt_mask(input logic [FMT_W-1:0] fmt);
        logic [SAMPLE_W-1:0] m;
        case (fmt[2:1])
            2'd0:    m = 32'h0000_00FF;
            2'd1:    m = 32'h0000_FFFF;
            2'd2:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // width minus one (index of the sign bit) for a format
    function automatic logic [4:0] fmt_msb(input logic [FMT_W-1:0] fmt);
        return {fmt[2:1], 3'b111};
    endfunction

endpackage

@@ rtl/pcmfc_front.sv @@
// pcmfc_front: takes raw samples and splits them into sign and magnitude
// per the source format. Depends on pcmfc_pkg.
module pcmfc_front (
    input  logic                              i_valid,
    input  logic [pcmfc_pkg::SAMPLE_W-1:0]    i_sample_in,
    input  logic                              i_last_in,
    input  logic [pcmfc_pkg::FMT_W-1:0]       i_src_fmt,
    input  logic                              i_q_full,
    output logic                              o_stall,
    output logic                              o_push,
    output pcmfc_pkg::t_cls                   o_cls
);

    logic [pcmfc_pkg::SAMPLE_W-1:0] w_mask;
    logic [pcmfc_pkg::SAMPLE_W-1:0] w_half;
    logic [pcmfc_pkg::SAMPLE_W-1:0] w_bits;
    logic                           w_neg;

    // stall whenever the queue has no free slot
    assign o_stall = i_q_full;
    assign o_push  = i_valid & ~i_q_full;

    // offset binary becomes two's complement by flipping the top bit
    always_comb begin
        w_mask = pcmfc_pkg::fmt_mask(i_src_fmt);
        w_half = 32'd1 << pcmfc_pkg::fmt_msb(i_src_fmt);
        w_bits = i_sample_in & w_mask;
        if (i_src_fmt[0]) begin
            w_bits = w_bits ^ w_half;
        end
        w_neg = |(w_bits & w_half);
    end

    // magnitude; the most negative code maps to the half scale on its own
    always_comb begin
        o_cls.s_neg = w_neg;
        o_cls.s_mag = w_neg ? ((~w_bits + 32'd1) & w_mask) : w_bits;
        o_cls.last  = i_last_in;
    end

endmodule

@@ rtl/pcmfc_queue.sv @@
// pcmfc_queue: short first-in first-out queue of classified items between
// the front and back parts. Depends on pcmfc_pkg.
module pcmfc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pcmfc_pkg::t_cls   i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_nempty,
    output pcmfc_pkg::t_cls   o_data
);

    pcmfc_pkg::t_cls                r_mem [pcmfc_pkg::Q_DEPTH];
    logic [pcmfc_pkg::Q_AW-1:0]     r_wr;
    logic [pcmfc_pkg::Q_AW-1:0]     r_rd;
    logic [pcmfc_pkg::Q_CW-1:0]     r_count;
    logic [pcmfc_pkg::Q_AW-1:0]     n_wr;
    logic [pcmfc_pkg::Q_AW-1:0]     n_rd;
    logic [pcmfc_pkg::Q_CW-1:0]     n_count;

    assign o_full   = (r_count == pcmfc_pkg::Q_CW'(pcmfc_pkg::Q_DEPTH));
    assign o_nempty = (r_count != '0);
    assign o_data   = r_mem[r_rd];

    // pointer and fill count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == pcmfc_pkg::Q_AW'(pcmfc_pkg::Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == pcmfc_pkg::Q_AW'(pcmfc_pkg::Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pcmfc_pkg::Q_CW'(pcmfc_pkg::Q_DEPTH))
        else $error("queue fill count beyond depth");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nempty)
        else $error("pop from empty queue");

    // pointers meet when the queue is empty or full
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || o_full) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with fill count");

    // a push alone grows the count by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not grow on push");

endmodule

@@ rtl/pcmfc_back.sv @@
// pcmfc_back: three-stage gain, clamp, rescale and saturate pipeline that
// drains the queue. Depends on pcmfc_pkg.
module pcmfc_back #(
    parameter int GAIN_FRAC_BITS = pcmfc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pcmfc_pkg::t_cfg                   i_cfg,
    input  logic                              i_q_nempty,
    input  pcmfc_pkg::t_cls                   i_q_data,
    output logic                              o_pop,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic [pcmfc_pkg::SAMPLE_W-1:0]    o_sample_out,
    output logic                              o_last_out
);

    logic        w_en1;
    logic        w_en2;
    logic        w_en3;

    // stage registers
    logic        r_v1;
    logic        r_v2;
    logic        r_v3;
    logic [63:0] r_prod;
    logic        r_neg1;
    logic        r_last1;
    logic [32:0] r_q;
    logic        r_neg2;
    logic        r_last2;
    logic [31:0] r_out;
    logic        r_last3;

    logic [31:0] w_gmag;
    logic        w_gneg;
    logic [5:0]  w_e;
    logic [5:0]  w_dsh;
    logic [63:0] w_lim;
    logic [63:0] w_magc;
    logic [63:0] w_shift;
    logic [32:0] w_top;
    logic [32:0] w_qs;
    logic [32:0] w_val;

    // each stage moves when the one after it has room
    assign w_en3 = ~r_v3 | ~i_stall;
    assign w_en2 = ~r_v2 | w_en3;
    assign w_en1 = ~r_v1 | w_en2;
    assign o_pop = i_q_nempty & w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_q_nempty;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // stage 1: gain magnitude and the 32 by 32 product
    assign w_gneg = i_cfg.gain[31];
    assign w_gmag = w_gneg ? (~i_cfg.gain + 32'd1) : i_cfg.gain;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_prod  <= {32'd0, i_q_data.s_mag} * {32'd0, w_gmag};
            r_neg1  <= i_q_data.s_neg ^ w_gneg;
            r_last1 <= i_q_data.last;
        end
    end

    // stage 2: clamp to unity, then align to the destination scale
    always_comb begin
        w_e    = {1'b0, pcmfc_pkg::fmt_msb(i_cfg.src_fmt)} + 6'(GAIN_FRAC_BITS);
        w_dsh  = {1'b0, pcmfc_pkg::fmt_msb(i_cfg.dst_fmt)};
        w_lim  = 64'd1 << w_e;
        w_magc = (r_prod > w_lim) ? w_lim : r_prod;
        if (w_e >= w_dsh) begin
            w_shift = w_magc >> (w_e - w_dsh);
        end else begin
            w_shift = w_magc << (w_dsh - w_e);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_q     <= w_shift[32:0];
            r_neg2  <= r_neg1;
            r_last2 <= r_last1;
        end
    end

    // stage 3: saturate positive full scale, restore sign, add offset for offset-binary output
    always_comb begin
        w_top = 33'd1 << w_dsh;
        w_qs  = r_q;
        if (!r_neg2 && r_q == w_top) begin
            w_qs = w_top - 33'd1;
        end
        w_val = r_neg2 ? (~w_qs + 33'd1) : w_qs;
        if (i_cfg.dst_fmt[0]) begin
            w_val = w_val + w_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_out   <= w_val[31:0] & pcmfc_pkg::fmt_mask(i_cfg.dst_fmt);
            r_last3 <= r_last2;
        end
    end

    assign o_valid      = r_v3;
    assign o_sample_out = r_out;
    assign o_last_out   = r_last3;

endmodule

@@ rtl/pcm_sample_format_converter_core.sv @@
// pcm_sample_format_converter_core: top level with configuration registers,
// front classifier, decoupling queue and back arithmetic pipeline.
// Depends on pcmfc_pkg, pcmfc_front, pcmfc_queue, pcmfc_back.
//
// Converts one pcm sample per item from the source format to the destination
// format, applying a signed fixed-point gain with clamping to full scale.
// Sustained rate is one item per clock cycle while the output is not stalled.
// An accepted item is written into the four-entry queue, then passes three
// back-end stages (32 by 32 multiply, clamp and rescale, saturate and offset)
// before it shows at the output. The last mark travels with its sample.
// Configuration writes take effect at once and are meant for when no item is
// in flight.
module pcm_sample_format_converter_core #(
    parameter int GAIN_FRAC_BITS = pcmfc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [pcmfc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pcmfc_pkg::GAIN_W-1:0]        i_cfg_data,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [pcmfc_pkg::SAMPLE_W-1:0]      i_sample_in,
    input  logic                                i_last_in,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [pcmfc_pkg::SAMPLE_W-1:0]      o_sample_out,
    output logic                                o_last_out
);

    logic [pcmfc_pkg::FMT_W-1:0]   r_src_fmt;
    logic [pcmfc_pkg::FMT_W-1:0]   r_dst_fmt;
    logic [pcmfc_pkg::GAIN_W-1:0]  r_gain;
    pcmfc_pkg::t_cfg               w_cfg;
    pcmfc_pkg::t_cls               w_push_data;
    pcmfc_pkg::t_cls               w_pop_data;
    logic                          w_push;
    logic                          w_pop;
    logic                          w_full;
    logic                          w_nempty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= pcmfc_pkg::FMT_S16;
            r_dst_fmt <= pcmfc_pkg::FMT_S16;
            r_gain    <= pcmfc_pkg::GAIN_W'(64'd1 << GAIN_FRAC_BITS);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcmfc_pkg::CFG_SRC_FMT: r_src_fmt <= i_cfg_data[pcmfc_pkg::FMT_W-1:0];
                pcmfc_pkg::CFG_DST_FMT: r_dst_fmt <= i_cfg_data[pcmfc_pkg::FMT_W-1:0];
                pcmfc_pkg::CFG_GAIN:    r_gain    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cfg.src_fmt = r_src_fmt;
    assign w_cfg.dst_fmt = r_dst_fmt;
    assign w_cfg.gain    = r_gain;

    // front: accept and classify
    pcmfc_front u_front (
        .i_valid     (i_valid),
        .i_sample_in (i_sample_in),
        .i_last_in   (i_last_in),
        .i_src_fmt   (r_src_fmt),
        .i_q_full    (w_full),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_cls       (w_push_data)
    );

    // decoupling queue
    pcmfc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_data),
        .i_pop    (w_pop),
        .o_full   (w_full),
        .o_nempty (w_nempty),
        .o_data   (w_pop_data)
    );

    // back: gain and format arithmetic
    pcmfc_back #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_q_nempty   (w_nempty),
        .i_q_data     (w_pop_data),
        .o_pop        (w_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_sample_out (o_sample_out),
        .o_last_out   (o_last_out)
    );

endmodule

@@ tb/pcm_sample_format_converter_core_tb.sv @@
// testbench for pcm_sample_format_converter_core: a table of directed items, then random
// items under several format and gain settings, checked against an in-bench predictor
// depends on pcmfc_pkg and the core rtl
module pcm_sample_format_converter_core_tb;

    localparam int GFB          = pcmfc_pkg::GAIN_FRAC_BITS_DEF;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 40;
    localparam int BLOCK_ITEMS  = 83;
    localparam int N_ROWS       = 25;

    // register index with no register behind it
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // gain settings of interest
    localparam logic [31:0] GAIN_UNITY     = 32'h0100_0000;
    localparam logic [31:0] GAIN_NEG_UNITY = 32'hFF00_0000;
    localparam logic [31:0] GAIN_TWO       = 32'h0200_0000;
    localparam logic [31:0] GAIN_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] GAIN_MIN       = 32'h8000_0000;
    localparam logic [31:0] GAIN_ZERO      = 32'h0000_0000;
    localparam logic [31:0] GAIN_SMALL     = 32'h0000_3000;

    typedef enum logic [2:0] {
        PCM_S8, PCM_U8, PCM_S16, PCM_U16, PCM_S24, PCM_U24, PCM_S32, PCM_U32
    } pcm_fmt_e;

    typedef struct packed {
        logic [31:0] sample;
        logic        last;
    } pcm_out_t;

    typedef struct {
        pcm_fmt_e    src;
        pcm_fmt_e    dst;
        logic [31:0] gain;
        logic [31:0] sample;
        logic        last;
        bit          typed;
        logic [31:0] want;
    } pcm_row_t;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [pcmfc_pkg::CFG_IDX_W-1:0]     i_cfg_idx;
    logic [pcmfc_pkg::GAIN_W-1:0]        i_cfg_data;
    logic                                i_valid;
    logic                                o_stall;
    logic [pcmfc_pkg::SAMPLE_W-1:0]      i_sample_in;
    logic                                i_last_in;
    logic                                o_valid;
    logic                                i_stall;
    logic [pcmfc_pkg::SAMPLE_W-1:0]      o_sample_out;
    logic                                o_last_out;

    // bench copy of the registers
    pcm_fmt_e    cur_src;
    pcm_fmt_e    cur_dst;
    logic [31:0] cur_gain;

    pcm_out_t    pending_samples[$];
    int          mismatch_count = 0;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_reqs;
    bit          fixed_on;
    logic [31:0] fixed_sample;
    int          quiet_cycles = 0;
    pcm_row_t    dir_rows [N_ROWS];

    pcm_sample_format_converter_core #(
        .GAIN_FRAC_BITS(GFB)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample_in (i_sample_in),
        .i_last_in   (i_last_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_sample_out(o_sample_out),
        .o_last_out  (o_last_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int fmt_bits(input pcm_fmt_e fmt);
        return 8 * (int'(fmt[2:1]) + 1);
    endfunction

    // normalise, apply gain, clamp to full scale, rescale and saturate
    function automatic logic [31:0] convert_sample(input logic [31:0] raw, input pcm_fmt_e src,
                                                   input pcm_fmt_e dst, input logic [31:0] gain);
        int          sw;
        int          dw;
        int          e;
        int          dsh;
        logic [63:0] smask;
        logic [63:0] dmask;
        logic [63:0] half_s;
        logic [63:0] bits;
        logic [63:0] s_mag;
        logic [63:0] g_mag;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] val;
        logic        s_neg;
        logic        neg;
        sw     = fmt_bits(src);
        dw     = fmt_bits(dst);
        smask  = (64'd1 << sw) - 64'd1;
        dmask  = (64'd1 << dw) - 64'd1;
        half_s = 64'd1 << (sw - 1);
        bits   = {32'd0, raw} & smask;
        // offset binary to two's complement
        if (src[0]) begin
            bits = bits ^ half_s;
        end
        s_neg = (bits & half_s) != 64'd0;
        s_mag = s_neg ? ((~bits + 64'd1) & smask) : bits;
        g_mag = {32'd0, gain[31] ? (~gain + 32'd1) : gain};
        neg   = s_neg ^ gain[31];
        mag   = s_mag * g_mag;
        e     = sw - 1 + GFB;
        dsh   = dw - 1;
        // clamp to [-1, 1]
        if (mag > (64'd1 << e)) begin
            mag = 64'd1 << e;
        end
        q = (e >= dsh) ? (mag >> (e - dsh)) : (mag << (dsh - e));
        // saturate to the signed destination range
        if (!neg && q > (64'd1 << dsh) - 64'd1) begin
            q = (64'd1 << dsh) - 64'd1;
        end
        if (neg && q > (64'd1 << dsh)) begin
            q = 64'd1 << dsh;
        end
        val = neg ? (~q + 64'd1) : q;
        if (dst[0]) begin
            val = val + (64'd1 << dsh);
        end
        return val[31:0] & dmask[31:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // expectations are queued on input acceptance and checked on output acceptance
    always @(posedge i_clk) begin : result_check
        pcm_out_t want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                want.sample = fixed_on ? fixed_sample
                                       : convert_sample(i_sample_in, cur_src, cur_dst, cur_gain);
                want.last   = i_last_in;
                pending_samples.push_back(want);
            end
            if (o_valid && !i_stall) begin
                if (pending_samples.size() == 0) begin
                    report_mismatch("unexpected item", o_sample_out, 32'd0);
                end else begin
                    want = pending_samples.pop_front();
                    if (o_sample_out !== want.sample) begin
                        report_mismatch("sample_out", o_sample_out, want.sample);
                    end
                    if (o_last_out !== want.last) begin
                        report_mismatch("last_out", {31'd0, o_last_out}, {31'd0, want.last});
                    end
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off on request
    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != hold_seen) begin
                hold_left = HOLD_CYCLES;
                hold_seen = hold_reqs;
            end
            if (hold_left > 0) begin
                i_stall   = 1'b1;
                hold_left = hold_left - 1;
            end else begin
                i_stall = ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // offer one item, idling first at random, and hold it until taken
    task automatic send_sample(input logic [31:0] smp, input logic lst);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_sample_in = smp;
        i_last_in   = lst;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        @(negedge i_clk);
    endtask

    // let every item drain before touching the registers
    task automatic wait_idle();
        i_valid = 1'b0;
        while (pending_samples.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic program_regs(input pcm_fmt_e src, input pcm_fmt_e dst, input logic [31:0] gain);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = pcmfc_pkg::CFG_SRC_FMT;
        i_cfg_data = {29'd0, src};
        @(negedge i_clk);
        i_cfg_idx  = pcmfc_pkg::CFG_DST_FMT;
        i_cfg_data = {29'd0, dst};
        @(negedge i_clk);
        i_cfg_idx  = pcmfc_pkg::CFG_GAIN;
        i_cfg_data = gain;
        @(negedge i_clk);
        // a write to the spare index must change nothing
        i_cfg_idx  = CFG_UNUSED;
        i_cfg_data = $urandom;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cur_src  = src;
        cur_dst  = dst;
        cur_gain = gain;
    endtask

    function automatic logic [31:0] pick_gain();
        logic [31:0] g;
        case ($urandom_range(0, 5))
            0: g = GAIN_UNITY;
            1: g = $urandom;
            2: g = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
            3: begin
                case ($urandom_range(0, 3))
                    0:       g = GAIN_MAX;
                    1:       g = GAIN_MIN;
                    2:       g = GAIN_ZERO;
                    default: g = GAIN_NEG_UNITY;
                endcase
            end
            default: begin
                g = $urandom_range(0, 32'h0200_0000);
                if ($urandom_range(0, 1) == 1) begin
                    g = ~g + 32'd1;
                end
            end
        endcase
        return g;
    endfunction

    // random bits, the low part sometimes zero, all ones, half scale or one below it
    function automatic logic [31:0] pick_sample();
        logic [31:0] r;
        logic [63:0] smask;
        logic [63:0] v;
        int          sw;
        r     = $urandom;
        sw    = fmt_bits(cur_src);
        smask = (64'd1 << sw) - 64'd1;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0:       v = 64'd0;
                1:       v = (64'd1 << (sw - 1)) - 64'd1;
                2:       v = 64'd1 << (sw - 1);
                default: v = smask;
            endcase
            r = (r & ~smask[31:0]) | v[31:0];
        end
        return r;
    endfunction

    initial begin : stimulus
        int phase;
        int blk;
        int n;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = pcmfc_pkg::CFG_SRC_FMT;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_sample_in    = '0;
        i_last_in      = 1'b0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_reqs      = 0;
        fixed_on       = 1'b0;
        fixed_sample   = '0;
        cur_src        = PCM_S16;
        cur_dst        = PCM_S16;
        cur_gain       = GAIN_UNITY;

        // src, dst, gain, sample, last, typed, expected
        dir_rows = '{
            // reset settings: s16 in, s16 out, unity gain
            '{PCM_S16, PCM_S16, GAIN_UNITY,     32'h0000_7FFF, 1'b0, 1'b1, 32'h0000_7FFF},
            '{PCM_S16, PCM_S16, GAIN_UNITY,     32'h0000_8000, 1'b1, 1'b1, 32'h0000_8000},
            '{PCM_S16, PCM_S16, GAIN_UNITY,     32'hFFFF_0001, 1'b0, 1'b1, 32'h0000_0001},
            '{PCM_S16, PCM_S16, GAIN_UNITY,     32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
            // signed to unsigned, extremes and midpoint
            '{PCM_S8,  PCM_U8,  GAIN_UNITY,     32'h0000_007F, 1'b0, 1'b1, 32'h0000_00FF},
            '{PCM_S8,  PCM_U8,  GAIN_UNITY,     32'hFFFF_FF80, 1'b0, 1'b1, 32'h0000_0000},
            '{PCM_S8,  PCM_U8,  GAIN_UNITY,     32'h0000_0000, 1'b1, 1'b1, 32'h0000_0080},
            // unsigned 24-bit read as plain offset binary
            '{PCM_U24, PCM_S24, GAIN_UNITY,     32'h0000_0000, 1'b0, 1'b1, 32'h0080_0000},
            '{PCM_U24, PCM_S24, GAIN_UNITY,     32'h00FF_FFFF, 1'b0, 1'b1, 32'h007F_FFFF},
            '{PCM_U24, PCM_S24, GAIN_UNITY,     32'hAB80_0000, 1'b0, 1'b1, 32'h0000_0000},
            // gain of two drives both ends into the clamp
            '{PCM_S32, PCM_U32, GAIN_TWO,       32'h4000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF},
            '{PCM_S32, PCM_U32, GAIN_TWO,       32'h8000_0000, 1'b0, 1'b1, 32'h0000_0000},
            '{PCM_S32, PCM_U32, GAIN_TWO,       32'h0000_0001, 1'b1, 1'b0, 32'h0000_0000},
            // negative gain inverts, full-scale negative saturates positive
            '{PCM_S16, PCM_S16, GAIN_NEG_UNITY, 32'h0000_8000, 1'b0, 1'b1, 32'h0000_7FFF},
            '{PCM_S16, PCM_S16, GAIN_NEG_UNITY, 32'h0000_7FFF, 1'b0, 1'b1, 32'h0000_8001},
            '{PCM_S16, PCM_S16, GAIN_NEG_UNITY, 32'h0000_0001, 1'b0, 1'b1, 32'h0000_FFFF},
            // most negative gain
            '{PCM_S8,  PCM_S32, GAIN_MIN,       32'h0000_0080, 1'b0, 1'b1, 32'h7FFF_FFFF},
            '{PCM_S8,  PCM_S32, GAIN_MIN,       32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
            // zero gain gives signed zero
            '{PCM_U16, PCM_S8,  GAIN_ZERO,      32'h0000_FFFF, 1'b0, 1'b1, 32'h0000_0000},
            '{PCM_U16, PCM_S8,  GAIN_ZERO,      32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
            // largest gain
            '{PCM_S32, PCM_S16, GAIN_MAX,       32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
            '{PCM_S32, PCM_S16, GAIN_MAX,       32'h8000_0001, 1'b0, 1'b1, 32'h0000_8000},
            // small gain, truncation toward zero
            '{PCM_U32, PCM_U16, GAIN_SMALL,     32'h1234_5678, 1'b0, 1'b0, 32'h0000_0000},
            '{PCM_U32, PCM_U16, GAIN_SMALL,     32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
            // narrow to wide
            '{PCM_U8,  PCM_S24, GAIN_UNITY,     32'h0000_00FF, 1'b0, 1'b1, 32'h007F_0000}
        };

        // reset
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed table, first rows on the reset settings
        for (n = 0; n < N_ROWS; n++) begin
            if (dir_rows[n].src != cur_src || dir_rows[n].dst != cur_dst ||
                dir_rows[n].gain != cur_gain) begin
                wait_idle();
                program_regs(dir_rows[n].src, dir_rows[n].dst, dir_rows[n].gain);
            end
            fixed_on     = dir_rows[n].typed;
            fixed_sample = dir_rows[n].want;
            send_sample(dir_rows[n].sample, dir_rows[n].last);
        end
        wait_idle();
        fixed_on = 1'b0;

        // random part: three idling patterns, several settings in each
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 57;
                end
                1: begin
                    send_idle_pct = 57;
                    recv_idle_pct = 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (blk = 0; blk < 5; blk++) begin
                wait_idle();
                program_regs(pcm_fmt_e'($urandom_range(0, 7)), pcm_fmt_e'($urandom_range(0, 7)),
                             pick_gain());
                // long hold-off on the output while items keep coming
                if (phase == 2 && blk == 0) begin
                    hold_reqs = hold_reqs + 1;
                end
                for (n = 0; n < BLOCK_ITEMS; n++) begin
                    send_sample(pick_sample(), $urandom_range(0, 7) == 0);
                end
            end
        end

        // drain and settle
        i_valid = 1'b0;
        while (pending_samples.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/pcmfc_pkg.sv
rtl/pcmfc_front.sv
rtl/pcmfc_queue.sv
rtl/pcmfc_back.sv
rtl/pcm_sample_format_converter_core.sv
tb/pcm_sample_format_converter_core_tb.sv
